// ===== rtl/core/x86_alu_with_flags_defines.svh =====
// Assertion macros for the x86 ALU RTL.
`ifndef X86_ALU_WITH_FLAGS_DEFINES_SVH
`define X86_ALU_WITH_FLAGS_DEFINES_SVH

`ifndef SYNTHESIS
`define XALU_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define XALU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define XALU_ASSERT(lbl, clk, rst_n, prop, msg)
`define XALU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/core/xalu_pkg.sv =====
// Types and constants for the x86 ALU with flags.
package xalu_pkg;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_AND = 2'd2;
	localparam logic [1:0] OP_INC = 2'd3;

	localparam logic [1:0] SZ_8  = 2'd0;
	localparam logic [1:0] SZ_16 = 2'd1;

	localparam int FL_CF = 0;
	localparam int FL_PF = 1;
	localparam int FL_AF = 2;
	localparam int FL_ZF = 3;
	localparam int FL_SF = 4;
	localparam int FL_OF = 5;
	localparam int FL_W  = 6;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [1:0]  op_size;
		logic [31:0] dest_value;
		logic [31:0] src_value;
	} req_t;

	typedef struct packed {
		logic [31:0] result;
		logic        carry_flag;
		logic        parity_flag;
		logic        adjust_flag;
		logic        zero_flag;
		logic        sign_flag;
		logic        overflow_flag;
	} rsp_t;

	typedef logic [FL_W-1:0] flags_t;

endpackage

// ===== rtl/core/x86_alu_with_flags.sv =====
// x86 integer ALU (ADD, SUB, AND, INC) with eager flag computation.
//
//  channel | direction | payload | handshake
//  req     | in        | req_t   | req_valid / req_ready
//  rsp     | out       | rsp_t   | rsp_valid / rsp_ready
//
// A request beat passes the input register, then the result register, before response valid.
// One beat per cycle sustained while rsp_ready holds; the kept CF/AF feed back from the flag register.
// Flag register updates as each item enters the result register.
// A stalled response holds the result register; the input register still takes one beat if empty.
// Reset clears the flags and both valid bits.
`include "x86_alu_with_flags_defines.svh"

module x86_alu_with_flags import xalu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic   valid_s1;
	req_t   req_s1;
	logic   rsp_valid_q;
	rsp_t   rsp_q;
	flags_t flags_q;
	logic   adv;
	rsp_t   calc;

	function automatic logic top_bit(input logic [31:0] v, input logic [1:0] sz);
		case (sz)
			SZ_8:    top_bit = v[7];
			SZ_16:   top_bit = v[15];
			default: top_bit = v[31];
		endcase
	endfunction

	assign adv       = !rsp_valid_q || rsp_ready;
	assign req_ready = !valid_s1 || adv;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		logic [31:0] mask;
		logic [31:0] d;
		logic [31:0] s;
		logic [31:0] r;
		logic [32:0] sum;
		logic        cf;
		logic        af;
		logic        of;
		case (req_s1.op_size)
			SZ_8:    mask = 32'h0000_00FF;
			SZ_16:   mask = 32'h0000_FFFF;
			default: mask = 32'hFFFF_FFFF;
		endcase
		d   = req_s1.dest_value & mask;
		s   = req_s1.src_value & mask;
		sum = {1'b0, d} + {1'b0, s};
		cf  = flags_q[FL_CF];
		af  = flags_q[FL_AF];
		of  = 1'b0;
		case (req_s1.req_type)
			OP_ADD: begin
				r  = sum[31:0] & mask;
				cf = top_bit(sum[32:1], req_s1.op_size);
				af = (d[4] ^ s[4] ^ r[4]);
				of = top_bit((d ^ r) & (s ^ r), req_s1.op_size);
			end
			OP_SUB: begin
				r  = (d - s) & mask;
				cf = (d < s);
				af = (d[4] ^ s[4] ^ r[4]);
				of = top_bit((d ^ s) & (d ^ r), req_s1.op_size);
			end
			OP_AND: begin
				r  = d & s;
				cf = 1'b0;
			end
			default: begin
				r  = (d + 32'd1) & mask;
				af = (d[4] ^ r[4]);
				of = top_bit((d ^ r) & (32'd1 ^ r), req_s1.op_size);
			end
		endcase
		calc.result        = r;
		calc.carry_flag    = cf;
		calc.parity_flag   = ~^r[7:0];
		calc.adjust_flag   = af;
		calc.zero_flag     = (r == 32'd0);
		calc.sign_flag     = top_bit(r, req_s1.op_size);
		calc.overflow_flag = of;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			flags_q     <= '0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (adv) begin
				rsp_valid_q <= valid_s1;
			end
			if (adv && valid_s1) begin
				flags_q[FL_CF] <= calc.carry_flag;
				flags_q[FL_PF] <= calc.parity_flag;
				flags_q[FL_AF] <= calc.adjust_flag;
				flags_q[FL_ZF] <= calc.zero_flag;
				flags_q[FL_SF] <= calc.sign_flag;
				flags_q[FL_OF] <= calc.overflow_flag;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
		if (adv && valid_s1) begin
			rsp_q <= calc;
		end
	end

	`XALU_ASSERT(a_flags_mirror, clk, arst_n, rsp_valid_q |-> (flags_q[FL_CF] == rsp_q.carry_flag && flags_q[FL_AF] == rsp_q.adjust_flag && flags_q[FL_OF] == rsp_q.overflow_flag), "kept flags differ from delivered beat")
	`XALU_ASSERT(a_zero_flag, clk, arst_n, rsp_valid_q |-> (rsp_q.zero_flag == (rsp_q.result == 32'd0)), "ZF disagrees with result")
	`XALU_ASSERT_NEXT(a_advance, clk, arst_n, valid_s1 && adv, rsp_valid_q, "stage 1 beat lost")
	`XALU_ASSERT_NEXT(a_and_clear, clk, arst_n, valid_s1 && adv && req_s1.req_type == OP_AND, !rsp_q.carry_flag && !rsp_q.overflow_flag, "AND left CF or OF set")
	`XALU_ASSERT(a_ready_empty, clk, arst_n, !rsp_valid_q |-> req_ready, "ready low with empty output")

endmodule
